### rtl/core/cbf_pkg.sv
`timescale 1ns / 1ps
// Shared constants, operation codes and memory command type for the counting Bloom filter.
package cbf_pkg;

    localparam int COUNTER_COUNT_DEF = 8192;
    localparam int COUNTER_WIDTH_DEF = 8;
    localparam int HASH_COUNT_DEF    = 7;

    localparam int SEED_REGS  = 7;
    localparam int SEED_IDX_W = 3;
    localparam int KEY_W      = 32;
    localparam int OP_W       = 2;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_QUERY  = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef struct packed {
        logic rd;
        logic wr;
    } mem_cmd_t;

endpackage

### rtl/core/cbf_if.sv
`timescale 1ns / 1ps
// Channel interfaces: input items, results and configuration writes.
interface cbf_item_if;
    logic                        valid;
    logic                        ready;
    logic [cbf_pkg::OP_W-1:0]    operation;
    logic [cbf_pkg::KEY_W-1:0]   element;

    modport source (output valid, operation, element, input ready);
    modport sink   (input valid, operation, element, output ready);
endinterface

interface cbf_result_if;
    logic valid;
    logic ready;
    logic present;
    logic saturated;

    modport source (output valid, present, saturated, input ready);
    modport sink   (input valid, present, saturated, output ready);
endinterface

interface cbf_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [cbf_pkg::SEED_IDX_W-1:0]   index;
    logic [cbf_pkg::KEY_W-1:0]        data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### rtl/core/counting_bloom_filter_top.sv
`timescale 1ns / 1ps
// Counting Bloom filter top level: seed registers, sequencer and result register.
//
// Channels: item (operation, element) in, result (present, saturated) out, cfg
// writes seed registers 0..6; cfg is always ready, higher indices are dropped.
// An insert or remove does HASH_COUNT read-modify-writes on one single-port
// counter memory; a query only reads and OP_NONE touches none. Per hash the
// index is formed, then read, then modify/write. With a power-of-two
// COUNTER_COUNT the index is a mask of the hashed key. Otherwise it comes
// from a reciprocal multiply and a correcting subtract, each registered.
// item.ready is high only while the sequencer is idle, so one item is in
// flight at a time; the next is taken while a result waits.
// Reset: seeds return to 1..7, then a clearing pass zeroes the counters,
// one per cycle, with item.ready low throughout.
// A stalled result receiver holds the result register; a finished item then
// waits in its output state and no further item is accepted until the
// register frees.
module counting_bloom_filter_top #(
    parameter int COUNTER_COUNT = cbf_pkg::COUNTER_COUNT_DEF,
    parameter int COUNTER_WIDTH = cbf_pkg::COUNTER_WIDTH_DEF,
    parameter int HASH_COUNT    = cbf_pkg::HASH_COUNT_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    cbf_item_if.sink      item,
    cbf_result_if.source  result,
    cbf_cfg_if.sink       cfg
);

    localparam int IDX_W = $clog2(COUNTER_COUNT);
    localparam int KW    = cbf_pkg::SEED_IDX_W;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_CLEAR  = 6'b000010,
        S_INDEX  = 6'b000100,
        S_READ   = 6'b001000,
        S_MODIFY = 6'b010000,
        S_OUT    = 6'b100000
    } state_t;

    state_t                     state_reg, state_next;
    logic [cbf_pkg::KEY_W-1:0]  seed_reg [cbf_pkg::SEED_REGS];
    logic [cbf_pkg::KEY_W-1:0]  element_reg, element_next;
    logic [cbf_pkg::OP_W-1:0]   op_reg, op_next;
    logic [KW-1:0]              k_reg, k_next;
    logic [IDX_W-1:0]           clr_reg, clr_next;
    logic                       present_reg, present_next;
    logic                       sat_reg, sat_next;
    logic                       res_valid_reg, res_valid_next;
    logic                       res_present_reg, res_present_next;
    logic                       res_sat_reg, res_sat_next;

    logic [KW-1:0]              hash_sel;
    logic [cbf_pkg::KEY_W-1:0]  key_sel;
    logic                       idx_start;
    logic [IDX_W-1:0]           idx;
    logic                       idx_done;
    cbf_pkg::mem_cmd_t          mem_cmd;
    logic [IDX_W-1:0]           mem_addr;
    logic [COUNTER_WIDTH-1:0]   mem_wdata;
    logic [COUNTER_WIDTH-1:0]   mem_rdata;
    logic                       out_free;

    cbf_index_unit #(
        .COUNTER_COUNT (COUNTER_COUNT),
        .IDX_W         (IDX_W)
    ) u_index (
        .clk   (clk),
        .rst_n (rst_n),
        .start (idx_start),
        .value (key_sel ^ seed_reg[hash_sel]),
        .idx   (idx),
        .done  (idx_done)
    );

    cbf_counter_mem #(
        .DEPTH (COUNTER_COUNT),
        .WIDTH (COUNTER_WIDTH),
        .AW    (IDX_W)
    ) u_mem (
        .clk   (clk),
        .cmd   (mem_cmd),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    assign item.ready       = (state_reg == S_IDLE);
    assign cfg.ready        = 1'b1;
    assign result.valid     = res_valid_reg;
    assign result.present   = res_present_reg;
    assign result.saturated = res_sat_reg;
    assign out_free         = !res_valid_reg || result.ready;

    always_comb
    begin
        state_next       = state_reg;
        element_next     = element_reg;
        op_next          = op_reg;
        k_next           = k_reg;
        clr_next         = clr_reg;
        present_next     = present_reg;
        sat_next         = sat_reg;
        res_valid_next   = res_valid_reg && !result.ready;
        res_present_next = res_present_reg;
        res_sat_next     = res_sat_reg;
        hash_sel         = '0;
        key_sel          = item.element;
        idx_start        = 1'b0;
        mem_cmd          = '0;
        mem_addr         = idx;
        mem_wdata        = '0;

        unique case (state_reg)
            S_CLEAR:
            begin
                mem_cmd.wr = 1'b1;
                mem_addr   = clr_reg;
                clr_next   = clr_reg + 1'b1;
                if (clr_reg == IDX_W'(COUNTER_COUNT - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (item.valid)
                begin
                    element_next = item.element;
                    op_next      = item.operation;
                    k_next       = '0;
                    present_next = (item.operation == cbf_pkg::OP_QUERY);
                    sat_next     = 1'b0;
                    if (item.operation == cbf_pkg::OP_NONE)
                    begin
                        state_next = S_OUT;
                    end
                    else
                    begin
                        idx_start  = 1'b1;
                        state_next = S_INDEX;
                    end
                end
            end
            S_INDEX:
            begin
                if (idx_done)
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                mem_cmd.rd = 1'b1;
                state_next = S_MODIFY;
            end
            S_MODIFY:
            begin
                unique case (op_reg)
                    cbf_pkg::OP_INSERT:
                    begin
                        mem_cmd.wr = 1'b1;
                        if (&mem_rdata)
                        begin
                            mem_wdata = mem_rdata;
                            sat_next  = 1'b1;
                        end
                        else
                        begin
                            mem_wdata = mem_rdata + 1'b1;
                        end
                    end
                    cbf_pkg::OP_REMOVE:
                    begin
                        mem_cmd.wr = 1'b1;
                        if (mem_rdata == '0)
                        begin
                            mem_wdata = mem_rdata;
                            sat_next  = 1'b1;
                        end
                        else
                        begin
                            mem_wdata = mem_rdata - 1'b1;
                        end
                    end
                    cbf_pkg::OP_QUERY:
                    begin
                        if (mem_rdata == '0)
                        begin
                            present_next = 1'b0;
                        end
                    end
                    default:
                    begin
                    end
                endcase
                key_sel = element_reg;
                if (k_reg == KW'(HASH_COUNT - 1))
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    hash_sel   = k_reg + 1'b1;
                    k_next     = k_reg + 1'b1;
                    idx_start  = 1'b1;
                    state_next = S_INDEX;
                end
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    res_valid_next   = 1'b1;
                    res_present_next = present_reg;
                    res_sat_next     = sat_reg;
                    state_next       = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            k_reg         <= '0;
            res_valid_reg <= 1'b0;
            for (int i = 0; i < cbf_pkg::SEED_REGS; i++)
            begin
                seed_reg[i] <= cbf_pkg::KEY_W'(i + 1);
            end
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            k_reg         <= k_next;
            res_valid_reg <= res_valid_next;
            if (cfg.valid && (cfg.index < KW'(cbf_pkg::SEED_REGS)))
            begin
                seed_reg[cfg.index] <= cfg.data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        element_reg     <= element_next;
        op_reg          <= op_next;
        present_reg     <= present_next;
        sat_reg         <= sat_next;
        res_present_reg <= res_present_next;
        res_sat_reg     <= res_sat_next;
    end

`ifndef SYNTHESIS
    a_result_from_out: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid_reg) |-> $past(state_reg == S_OUT))
        else $error("result raised outside output state");

    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        idx_done |-> (32'(idx) < 32'(COUNTER_COUNT)))
        else $error("counter index out of range");

    a_query_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MODIFY && op_reg == cbf_pkg::OP_QUERY) |-> !mem_cmd.wr)
        else $error("query wrote the counter memory");

    a_hash_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE && state_reg != S_CLEAR) |-> (32'(k_reg) < 32'(HASH_COUNT)))
        else $error("hash counter past last seed");

    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg |-> !(res_present_reg && res_sat_reg))
        else $error("present and saturated both set");
`endif

endmodule

### rtl/core/cbf_index_unit.sv
`timescale 1ns / 1ps
// Reduces a 32-bit hashed key to a counter index (mask, or reciprocal multiply and correction).
module cbf_index_unit #(
    parameter int COUNTER_COUNT = cbf_pkg::COUNTER_COUNT_DEF,
    parameter int IDX_W         = $clog2(COUNTER_COUNT)
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [cbf_pkg::KEY_W-1:0] value,
    output logic [IDX_W-1:0]          idx,
    output logic                      done
);

    localparam bit IS_POW2 = (COUNTER_COUNT & (COUNTER_COUNT - 1)) == 0;

    generate
        if (IS_POW2)
        begin : g_mask
            logic [IDX_W-1:0] idx_reg;
            logic             done_reg;

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    done_reg <= 1'b0;
                end
                else
                begin
                    done_reg <= start;
                end
            end

            always_ff @(posedge clk)
            begin
                if (start)
                begin
                    idx_reg <= value[IDX_W-1:0];
                end
            end

            assign idx  = idx_reg;
            assign done = done_reg;
        end
        else
        begin : g_recip
            // quotient estimate is the true quotient or one below it
            localparam logic [2*cbf_pkg::KEY_W-1:0] RECIP_WIDE =
                (64'd1 << cbf_pkg::KEY_W) / 64'(COUNTER_COUNT);
            localparam logic [cbf_pkg::KEY_W-1:0]   RECIP   = cbf_pkg::KEY_W'(RECIP_WIDE);
            localparam logic [IDX_W:0]              MODULUS = (IDX_W + 1)'(COUNTER_COUNT);

            logic [cbf_pkg::KEY_W-1:0]   val_reg;
            logic [cbf_pkg::KEY_W-1:0]   quot_reg;
            logic [IDX_W-1:0]            rem_reg;
            logic                        mul_reg;
            logic                        sub_reg;
            logic                        done_reg;
            logic [2*cbf_pkg::KEY_W-1:0] prod;
            logic [IDX_W:0]              back;
            logic [IDX_W:0]              diff;

            assign prod = (2*cbf_pkg::KEY_W)'(val_reg) * (2*cbf_pkg::KEY_W)'(RECIP);
            assign back = quot_reg[IDX_W:0] * MODULUS;
            assign diff = val_reg[IDX_W:0] - back;

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    mul_reg  <= 1'b0;
                    sub_reg  <= 1'b0;
                    done_reg <= 1'b0;
                end
                else
                begin
                    mul_reg  <= start;
                    sub_reg  <= mul_reg;
                    done_reg <= sub_reg;
                end
            end

            always_ff @(posedge clk)
            begin
                if (start)
                begin
                    val_reg <= value;
                end
                if (mul_reg)
                begin
                    quot_reg <= prod[2*cbf_pkg::KEY_W-1:cbf_pkg::KEY_W];
                end
                if (sub_reg)
                begin
                    if (diff >= MODULUS)
                    begin
                        rem_reg <= IDX_W'(diff - MODULUS);
                    end
                    else
                    begin
                        rem_reg <= diff[IDX_W-1:0];
                    end
                end
            end

            assign idx  = rem_reg;
            assign done = done_reg;
        end
    endgenerate

endmodule

### rtl/core/cbf_counter_mem.sv
`timescale 1ns / 1ps
// Single-port counter memory with registered read data.
module cbf_counter_mem #(
    parameter int DEPTH = cbf_pkg::COUNTER_COUNT_DEF,
    parameter int WIDTH = cbf_pkg::COUNTER_WIDTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic              clk,
    input  cbf_pkg::mem_cmd_t cmd,
    input  logic [AW-1:0]     addr,
    input  logic [WIDTH-1:0]  wdata,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.wr)
        begin
            mem[addr] <= wdata;
        end
        if (cmd.rd)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### tb/tb_counting_bloom_filter_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for the counting Bloom filter: stimulus, shadow filter and result check.
module tb_counting_bloom_filter_top;

    localparam int COUNTERS = cbf_pkg::COUNTER_COUNT_DEF;
    localparam int CTR_W    = cbf_pkg::COUNTER_WIDTH_DEF;
    localparam int HASHES   = cbf_pkg::HASH_COUNT_DEF;
    localparam logic [CTR_W-1:0] CTR_MAX = '1;

    typedef struct {
        cbf_pkg::op_t op;
        logic [31:0]  element;
        bit           present;
        bit           saturated;
    } filter_answer_t;

    logic clk;
    logic rst_n;

    cbf_item_if   item_ch ();
    cbf_result_if result_ch ();
    cbf_cfg_if    cfg_ch ();

    counting_bloom_filter_top #(
        .COUNTER_COUNT (COUNTERS),
        .COUNTER_WIDTH (CTR_W),
        .HASH_COUNT    (HASHES)
    ) DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    bit [CTR_W-1:0] shadow_counters [COUNTERS];
    logic [31:0]    shadow_seeds [cbf_pkg::SEED_REGS];
    filter_answer_t pending_answers [$];
    filter_answer_t want;
    int unsigned    error_count;
    bit             gaps_on = 1'b1;
    int unsigned    hold_cycles_req;
    int unsigned    hold_left;

    always #1 clk = ~clk;

    initial
    begin
        #2_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    task automatic report_mismatch(string msg);
        $display("MISMATCH at %0t: %s", $time, msg);
        error_count++;
    endtask

    function automatic void apply_filter_op(cbf_pkg::op_t op, logic [31:0] elem,
                                            output bit present, output bit saturated);
        int unsigned slot;
        present   = 1'b0;
        saturated = 1'b0;
        case (op)
            cbf_pkg::OP_INSERT:
                for (int k = 0; k < HASHES; k++)
                begin
                    slot = (elem ^ shadow_seeds[k]) % COUNTERS;
                    if (shadow_counters[slot] == CTR_MAX)
                        saturated = 1'b1;
                    else
                        shadow_counters[slot]++;
                end
            cbf_pkg::OP_REMOVE:
                for (int k = 0; k < HASHES; k++)
                begin
                    slot = (elem ^ shadow_seeds[k]) % COUNTERS;
                    if (shadow_counters[slot] == 0)
                        saturated = 1'b1;
                    else
                        shadow_counters[slot]--;
                end
            cbf_pkg::OP_QUERY:
            begin
                present = 1'b1;
                for (int k = 0; k < HASHES; k++)
                begin
                    slot = (elem ^ shadow_seeds[k]) % COUNTERS;
                    if (shadow_counters[slot] == 0)
                        present = 1'b0;
                end
            end
            default: ;
        endcase
    endfunction

    task automatic offer_item(cbf_pkg::op_t op, logic [31:0] elem);
        bit             present;
        bit             saturated;
        filter_answer_t ans;
        while (gaps_on && $urandom_range(99) < 20)
        begin
            item_ch.valid <= 1'b0;
            @(posedge clk);
        end
        item_ch.valid     <= 1'b1;
        item_ch.operation <= op;
        item_ch.element   <= elem;
        @(posedge clk);
        while (!item_ch.ready)
            @(posedge clk);
        apply_filter_op(op, elem, present, saturated);
        ans = '{op, elem, present, saturated};
        pending_answers.insert(pending_answers.size(), ans);
    endtask

    task automatic write_seed(logic [cbf_pkg::SEED_IDX_W-1:0] idx, logic [31:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        if (idx < cbf_pkg::SEED_REGS)
            shadow_seeds[idx] = value;
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic settle_filter();
        item_ch.valid <= 1'b0;
        while (pending_answers.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // result sink: random stalls, plus long hold-offs on request
    always @(posedge clk)
    begin
        if (hold_cycles_req != 0)
        begin
            hold_left       = hold_cycles_req;
            hold_cycles_req = 0;
        end
        if (hold_left != 0)
        begin
            hold_left--;
            result_ch.ready <= 1'b0;
        end
        else
            result_ch.ready <= !(gaps_on && $urandom_range(99) < 20);
    end

    // one beat per accepted result, matched against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (pending_answers.size() == 0)
                report_mismatch("result beat with no item outstanding");
            else
            begin
                want = pending_answers.pop_front();
                if (result_ch.present !== want.present)
                    report_mismatch($sformatf("present %b, wanted %b (%s %h)",
                        result_ch.present, want.present, want.op.name(), want.element));
                if (result_ch.saturated !== want.saturated)
                    report_mismatch($sformatf("saturated %b, wanted %b (%s %h)",
                        result_ch.saturated, want.saturated, want.op.name(), want.element));
            end
        end
    end

    task automatic test_directed_basics();
        offer_item(cbf_pkg::OP_QUERY,  32'h0000_0000);
        offer_item(cbf_pkg::OP_REMOVE, 32'h0000_0000);
        offer_item(cbf_pkg::OP_INSERT, 32'h0000_0000);
        offer_item(cbf_pkg::OP_QUERY,  32'h0000_0000);
        offer_item(cbf_pkg::OP_INSERT, 32'hFFFF_FFFF);
        offer_item(cbf_pkg::OP_QUERY,  32'hFFFF_FFFF);
        offer_item(cbf_pkg::OP_REMOVE, 32'hFFFF_FFFF);
        offer_item(cbf_pkg::OP_QUERY,  32'hFFFF_FFFF);
        offer_item(cbf_pkg::OP_NONE,   32'hFFFF_FFFF);
        offer_item(cbf_pkg::OP_NONE,   32'h0000_0000);
        offer_item(cbf_pkg::OP_QUERY,  32'h0000_0000);
        offer_item(cbf_pkg::OP_REMOVE, 32'h0000_0000);
        offer_item(cbf_pkg::OP_REMOVE, 32'h0000_0000);
        offer_item(cbf_pkg::OP_INSERT, 32'h8000_0000);
        offer_item(cbf_pkg::OP_QUERY,  32'h5555_5555);
        offer_item(cbf_pkg::OP_QUERY,  32'hAAAA_AAAA);
    endtask

    task automatic test_seed_registers();
        settle_filter();
        write_seed(3'd0, 32'h0000_0000);
        write_seed(3'd1, 32'hFFFF_FFFF);
        write_seed(3'd2, 32'h8000_0000);
        write_seed(3'd3, 32'h0000_0001);
        write_seed(3'd4, 32'h7FFF_FFFF);
        write_seed(3'd5, 32'hAAAA_AAAA);
        write_seed(3'd6, 32'h5555_5555);
        write_seed(3'd7, 32'hDEAD_BEEF);
        offer_item(cbf_pkg::OP_QUERY,  32'h8000_0000);
        offer_item(cbf_pkg::OP_INSERT, 32'h1234_5678);
        offer_item(cbf_pkg::OP_QUERY,  32'h1234_5678);
        // all seeds equal: every hash lands on one counter
        settle_filter();
        for (int k = 0; k < cbf_pkg::SEED_REGS; k++)
            write_seed(cbf_pkg::SEED_IDX_W'(k), 32'h0000_1234);
        offer_item(cbf_pkg::OP_INSERT, 32'hCAFE_F00D);
        offer_item(cbf_pkg::OP_REMOVE, 32'hCAFE_F00D);
        offer_item(cbf_pkg::OP_REMOVE, 32'hCAFE_F00D);
    endtask

    task automatic test_random_traffic(int unsigned count);
        logic [31:0] keys [$];
        logic [31:0] elem;
        int unsigned pick;
        int unsigned slot;
        for (int unsigned n = 0; n < count; n++)
        begin
            if (n == 0 || n == count / 2)
            begin
                settle_filter();
                for (int k = 0; k < cbf_pkg::SEED_REGS; k++)
                    write_seed(cbf_pkg::SEED_IDX_W'(k), $urandom);
                keys.delete();
            end
            gaps_on = !(n >= count / 4 && n < count / 4 + 200);
            pick = $urandom_range(99);
            elem = $urandom;
            if (pick < 35)
            begin
                if (keys.size() != 0 && $urandom_range(3) == 0)
                    elem = keys[$urandom_range(keys.size() - 1)];
                else
                begin
                    keys.insert(keys.size(), elem);
                    if (keys.size() > 64)
                        void'(keys.pop_front());
                end
                offer_item(cbf_pkg::OP_INSERT, elem);
            end
            else if (pick < 55)
            begin
                if (keys.size() != 0 && $urandom_range(4) != 0)
                begin
                    slot = $urandom_range(keys.size() - 1);
                    elem = keys[slot];
                    keys.delete(slot);
                end
                offer_item(cbf_pkg::OP_REMOVE, elem);
            end
            else if (pick < 95)
            begin
                if (keys.size() != 0 && $urandom_range(9) < 6)
                    elem = keys[$urandom_range(keys.size() - 1)];
                offer_item(cbf_pkg::OP_QUERY, elem);
            end
            else
                offer_item(cbf_pkg::OP_NONE, elem);
        end
        gaps_on = 1'b1;
    endtask

    task automatic test_backpressure(int unsigned count);
        gaps_on         = 1'b0;
        hold_cycles_req = 300;
        for (int unsigned n = 0; n < count; n++)
            offer_item(cbf_pkg::op_t'($urandom_range(2)), $urandom);
        gaps_on = 1'b1;
    endtask

    // few keys, shared seed: counters climb to the top, then drain past zero
    task automatic test_counter_limits(logic [31:0] common_seed, int unsigned phase_len);
        logic [31:0]  keys [3];
        int unsigned  pick;
        cbf_pkg::op_t main_op;
        cbf_pkg::op_t other_op;
        settle_filter();
        for (int k = 0; k < cbf_pkg::SEED_REGS; k++)
            write_seed(cbf_pkg::SEED_IDX_W'(k), common_seed);
        foreach (keys[i])
            keys[i] = $urandom;
        for (int phase = 0; phase < 2; phase++)
        begin
            main_op  = (phase == 0) ? cbf_pkg::OP_INSERT : cbf_pkg::OP_REMOVE;
            other_op = (phase == 0) ? cbf_pkg::OP_REMOVE : cbf_pkg::OP_INSERT;
            for (int unsigned n = 0; n < phase_len; n++)
            begin
                pick = $urandom_range(99);
                if (pick < 80)
                    offer_item(main_op, keys[$urandom_range(2)]);
                else if (pick < 90)
                    offer_item(cbf_pkg::OP_QUERY, keys[$urandom_range(2)]);
                else
                    offer_item(other_op, keys[$urandom_range(2)]);
            end
        end
    endtask

    initial
    begin
        clk               = 1'b0;
        rst_n             = 1'b0;
        item_ch.valid     = 1'b0;
        item_ch.operation = cbf_pkg::OP_NONE;
        item_ch.element   = '0;
        cfg_ch.valid      = 1'b0;
        cfg_ch.index      = '0;
        cfg_ch.data       = '0;
        result_ch.ready   = 1'b0;
        for (int k = 0; k < cbf_pkg::SEED_REGS; k++)
            shadow_seeds[k] = k + 1;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        // counter clearing pass runs with item ready low
        @(posedge clk);
        while (!item_ch.ready)
            @(posedge clk);

        test_directed_basics();
        test_seed_registers();
        test_random_traffic(1400);
        test_backpressure(30);
        test_counter_limits(32'hFFFF_FFFF, 200);
        test_counter_limits(32'h0000_0000, 200);

        item_ch.valid <= 1'b0;
        while (pending_answers.size() != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

### filelist.f
rtl/core/cbf_pkg.sv
rtl/core/cbf_if.sv
rtl/core/cbf_index_unit.sv
rtl/core/cbf_counter_mem.sv
rtl/core/counting_bloom_filter_top.sv
tb/tb_counting_bloom_filter_top.sv
